### design/modular_exponentiation_core_macros.svh
// Assertion macros for the modular exponentiation core.
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

`ifndef SYNTHESIS
// label: property checked at every rising edge of i_clk, off while in reset
`define MEXP_CHECK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
// label: expression that must never be true
`define MEXP_NEVER(label, expr, msg) \
    `MEXP_CHECK(label, !(expr), msg)
`else
`define MEXP_CHECK(label, prop, msg)
`define MEXP_NEVER(label, expr, msg)
`endif

`endif

### design/mexp_pkg.sv
// Shared constants for the modular exponentiation core.
package mexp_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int EXP_WIDTH  = 16;

    localparam int CFG_DATA_W = (DATA_WIDTH > EXP_WIDTH) ? DATA_WIDTH : EXP_WIDTH;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = CFG_IDX_W'(1);

    localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

endpackage

### design/modular_exponentiation_core.sv
// Modular exponentiation core: base^exponent mod modulus, bit-serial.
//
// One word in, one word out. A base word is taken only while the core is
// idle; a finished result waits in an output register so the next base can
// be taken while it is pending. Modulus (index 0) and exponent (index 1)
// are written on the config port, which is ready only while idle; other
// indexes are ignored. Modulus 0 gives 0 with modulus_error set, modulus 1
// gives 0; either goes straight from idle to the done state, which posts it
// once the output register is free. Otherwise the base is reduced and the
// exponent is scanned LSB first by one shared shift-and-add modular
// multiplier that handles one multiplier bit per cycle. A result that
// cannot enter a full output register holds the core until the word ahead
// of it is taken; the next base can be taken in the cycle after a result is
// posted. The multiplier sets the rate.
`include "modular_exponentiation_core_macros.svh"

module modular_exponentiation_core
    import mexp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_base_valid,
    output logic                  o_base_stall,
    input  logic [DATA_WIDTH-1:0] i_base,
    output logic                  o_res_valid,
    input  logic                  i_res_stall,
    output logic [DATA_WIDTH-1:0] o_power_mod,
    output logic                  o_modulus_error
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SQR  = 3'd3;
    localparam logic [2:0] S_NEXT = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]            r_state;
    logic [DATA_WIDTH-1:0] r_modulus;
    logic [EXP_WIDTH-1:0]  r_exponent;
    logic [EXP_WIDTH-1:0]  r_exp;
    logic [DATA_WIDTH-1:0] r_res;
    logic [DATA_WIDTH-1:0] r_pow;
    logic                  r_err;
    logic [DATA_WIDTH-1:0] r_acc;
    logic [DATA_WIDTH-1:0] r_mul_a;
    logic [DATA_WIDTH-1:0] r_mul_b;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_pow;
    logic                  r_out_err;

    logic                  base_accept;
    logic                  out_free;
    logic                  busy_mul;
    logic [DATA_WIDTH:0]   dbl_sum;
    logic [DATA_WIDTH-1:0] dbl_mod;
    logic [DATA_WIDTH:0]   add_sum;
    logic [DATA_WIDTH-1:0] add_mod;
    logic [DATA_WIDTH-1:0] n_acc;
    logic                  mul_last;

    assign o_cfg_ready  = (r_state == S_IDLE);
    assign o_base_stall = (r_state != S_IDLE);
    assign base_accept  = i_base_valid && (r_state == S_IDLE);
    assign out_free     = !r_out_valid || !i_res_stall;
    assign busy_mul     = r_state inside {S_RED, S_MUL, S_SQR};
    assign mul_last     = (r_cnt == CNT_LAST);

    // one multiplier bit: acc = 2*acc (+ a) mod n
    always_comb begin
        dbl_sum = {1'b0, r_acc} + {1'b0, r_acc};
        if (dbl_sum >= {1'b0, r_modulus}) begin
            dbl_mod = DATA_WIDTH'(dbl_sum - {1'b0, r_modulus});
        end else begin
            dbl_mod = dbl_sum[DATA_WIDTH-1:0];
        end
        add_sum = {1'b0, dbl_mod} + {1'b0, r_mul_a};
        if (add_sum >= {1'b0, r_modulus}) begin
            add_mod = DATA_WIDTH'(add_sum - {1'b0, r_modulus});
        end else begin
            add_mod = add_sum[DATA_WIDTH-1:0];
        end
        n_acc = r_mul_b[DATA_WIDTH-1] ? add_mod : dbl_mod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= DATA_WIDTH'(1);
            r_exponent <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MODULUS:  r_modulus  <= i_cfg_data[DATA_WIDTH-1:0];
                CFG_EXPONENT: r_exponent <= i_cfg_data[EXP_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (base_accept) begin
                        r_exp   <= r_exponent;
                        r_res   <= DATA_WIDTH'(1);
                        r_err   <= (r_modulus == '0);
                        r_acc   <= '0;
                        r_mul_a <= DATA_WIDTH'(1);
                        r_mul_b <= i_base;
                        r_cnt   <= '0;
                        if (r_modulus <= DATA_WIDTH'(1)) begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_RED;
                        end
                    end
                end
                S_RED, S_MUL, S_SQR: begin
                    r_acc   <= n_acc;
                    r_mul_b <= r_mul_b << 1;
                    r_cnt   <= r_cnt + CNT_W'(1);
                    if (mul_last) begin
                        r_acc <= '0;
                        r_cnt <= '0;
                        if (r_state == S_MUL) begin
                            r_res <= n_acc;
                            if ((r_exp >> 1) == '0) begin
                                r_exp   <= '0;
                                r_state <= S_NEXT;
                            end else begin
                                r_mul_a <= r_pow;
                                r_mul_b <= r_pow;
                                r_state <= S_SQR;
                            end
                        end else begin
                            r_pow   <= n_acc;
                            if (r_state == S_SQR) begin
                                r_exp <= r_exp >> 1;
                            end
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_NEXT: begin
                    if (r_exp == '0) begin
                        r_state <= S_DONE;
                    end else if (r_exp[0]) begin
                        r_mul_a <= r_res;
                        r_mul_b <= r_pow;
                        r_state <= S_MUL;
                    end else begin
                        r_mul_a <= r_pow;
                        r_mul_b <= r_pow;
                        r_state <= S_SQR;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_pow <= r_res;
            r_out_err <= r_err;
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_power_mod     = r_out_pow;
    assign o_modulus_error = r_out_err;

    `MEXP_CHECK(a_acc_below_mod, busy_mul |-> (r_acc < r_modulus), "accumulator not reduced")
    `MEXP_NEVER(a_err_nonzero, o_res_valid && o_modulus_error && (|o_power_mod), "bad error word")
    `MEXP_CHECK(a_accept_leaves_idle, base_accept |=> (r_state != S_IDLE), "base not started")
    `MEXP_CHECK(a_done_posts, (r_state == S_DONE && out_free) |=> o_res_valid, "not posted")

endmodule

### tb/sv/modular_exponentiation_core_tb.sv
// Self-checking testbench for the modular exponentiation core.
`timescale 1ns / 100ps

module modular_exponentiation_core_tb;
    import mexp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int SETTLE_CYCLES   = 600;
    localparam int RANDOM_PHASES   = 41;
    localparam int PHASE_WORDS     = 28;
    localparam int QUIET_PHASE     = 37;
    localparam int PRESSURE_PHASE  = 5;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] power_mod;
        logic                  modulus_error;
    } t_power_result;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] modulus;
        logic [EXP_WIDTH-1:0]  exponent;
        logic [DATA_WIDTH-1:0] base;
        logic                  known;
        logic [DATA_WIDTH-1:0] power_mod;
        logic                  modulus_error;
    } t_directed_row;

    // known = 1: result typed in; else taken from the predictor
    localparam t_directed_row DIRECTED_ROWS [23] = '{
        '{16'h0001, 16'h0000, 16'h1234, 1'b1, 16'h0000, 1'b0},
        '{16'h0000, 16'h0005, 16'hFFFF, 1'b1, 16'h0000, 1'b1},
        '{16'h0000, 16'hFFFF, 16'h0000, 1'b1, 16'h0000, 1'b1},
        '{16'h0001, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, 1'b0},
        '{16'hFFFF, 16'h0000, 16'hABCD, 1'b1, 16'h0001, 1'b0},
        '{16'h0002, 16'h0000, 16'h0000, 1'b1, 16'h0001, 1'b0},
        '{16'hFFFF, 16'h0001, 16'hFFFF, 1'b1, 16'h0000, 1'b0},
        '{16'hFFFF, 16'h0001, 16'hFFFE, 1'b1, 16'hFFFE, 1'b0},
        '{16'hFFFF, 16'h0002, 16'hFFFE, 1'b1, 16'h0001, 1'b0},
        '{16'hFFFF, 16'hFFFF, 16'hFFFE, 1'b1, 16'hFFFE, 1'b0},
        '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 16'h0000, 1'b0},
        '{16'hFFFF, 16'hFFFF, 16'h0001, 1'b1, 16'h0001, 1'b0},
        '{16'h0002, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0001, 1'b0},
        '{16'hFFFE, 16'hFFFF, 16'h1234, 1'b0, 16'h0000, 1'b0},
        '{16'hFFF1, 16'hFFF0, 16'h0002, 1'b1, 16'h0001, 1'b0},
        '{16'hFFF1, 16'h8000, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
        '{16'h8000, 16'h0003, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
        '{16'h0003, 16'h0002, 16'h0002, 1'b1, 16'h0001, 1'b0},
        '{16'h000D, 16'h0001, 16'h001A, 1'b1, 16'h0000, 1'b0},
        '{16'hAAAA, 16'h5555, 16'h5555, 1'b0, 16'h0000, 1'b0},
        '{16'h5555, 16'hAAAA, 16'hAAAA, 1'b0, 16'h0000, 1'b0},
        '{16'h0007, 16'h8001, 16'h0003, 1'b0, 16'h0000, 1'b0},
        '{16'h0001, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0}
    };

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = CFG_MODULUS;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_base_valid    = 1'b0;
    logic [DATA_WIDTH-1:0] i_base          = '0;
    logic                  i_res_stall     = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_base_stall;
    logic                  o_res_valid;
    logic [DATA_WIDTH-1:0] o_power_mod;
    logic                  o_modulus_error;

    t_power_result         pending_results[$];
    logic [DATA_WIDTH-1:0] cur_modulus  = DATA_WIDTH'(1);
    logic [EXP_WIDTH-1:0]  cur_exponent = '0;
    int                    failures     = 0;
    bit                    idling_on    = 1'b1;
    bit                    hold_off_now = 1'b0;

    modular_exponentiation_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_base_valid   (i_base_valid),
        .o_base_stall   (o_base_stall),
        .i_base         (i_base),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .o_power_mod    (o_power_mod),
        .o_modulus_error(o_modulus_error)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_power_result predict_power(input logic [DATA_WIDTH-1:0] b,
                                                    input logic [DATA_WIDTH-1:0] n,
                                                    input logic [EXP_WIDTH-1:0] e);
        t_power_result             r;
        logic [2*DATA_WIDTH-1:0]   prod;
        logic [DATA_WIDTH-1:0]     acc;
        logic [DATA_WIDTH-1:0]     sq;
        int                        i;
        r.power_mod     = '0;
        r.modulus_error = 1'b0;
        if (n == 0) begin
            r.modulus_error = 1'b1;
            return r;
        end
        if (n == 1) begin
            return r;
        end
        acc = DATA_WIDTH'(1);
        sq  = b % n;
        for (i = 0; i < EXP_WIDTH; i++) begin
            if (e[i]) begin
                prod = acc * sq;
                acc  = DATA_WIDTH'(prod % n);
            end
            prod = sq * sq;
            sq   = DATA_WIDTH'(prod % n);
        end
        r.power_mod = acc;
        return r;
    endfunction

    // caller lowers i_cfg_valid after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_MODULUS:  cur_modulus  = val[DATA_WIDTH-1:0];
            CFG_EXPONENT: cur_exponent = val[EXP_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [DATA_WIDTH-1:0] m, input logic [EXP_WIDTH-1:0] e);
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_MODULUS, CFG_DATA_W'(m));
            write_reg(CFG_EXPONENT, CFG_DATA_W'(e));
        end else begin
            write_reg(CFG_EXPONENT, CFG_DATA_W'(e));
            write_reg(CFG_MODULUS, CFG_DATA_W'(m));
        end
        if ($urandom_range(0, 1))
            write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        i_base_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // valid stays high after acceptance so back-to-back words need no toggle
    task automatic put_base(input logic [DATA_WIDTH-1:0] b, input bit known,
                            input t_power_result typed);
        int gap;
        gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
            i_base_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_base_valid <= 1'b1;
        i_base       <= b;
        @(posedge i_clk);
        while (o_base_stall) @(posedge i_clk);
        pending_results.insert(pending_results.size(),
                               known ? typed : predict_power(b, cur_modulus, cur_exponent));
    endtask

    initial begin : res_stall_driver
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_off_now) begin
                i_res_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_now = 1'b0;
                i_res_stall <= 1'b0;
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                i_res_stall <= 1'b1;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge i_clk);
                i_res_stall <= 1'b0;
            end else begin
                i_res_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_power_result want;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word: power_mod %h modulus_error %b",
                         $time, o_power_mod, o_modulus_error);
                failures++;
            end else begin
                want = pending_results.pop_front();
                if (o_power_mod !== want.power_mod) begin
                    $display("%0t: power_mod expected %h, actual %h",
                             $time, want.power_mod, o_power_mod);
                    failures++;
                end
                if (o_modulus_error !== want.modulus_error) begin
                    $display("%0t: modulus_error expected %b, actual %b",
                             $time, want.modulus_error, o_modulus_error);
                    failures++;
                end
            end
        end
    end

    initial begin : stimulus
        t_directed_row         row;
        t_power_result         typed;
        logic [DATA_WIDTH-1:0] m;
        logic [EXP_WIDTH-1:0]  e;
        logic [DATA_WIDTH-1:0] b;
        int                    p;
        int                    k;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[r]) begin
            row = DIRECTED_ROWS[r];
            if (row.modulus != cur_modulus || row.exponent != cur_exponent) begin
                drain_results();
                set_config(row.modulus, row.exponent);
            end
            typed.power_mod     = row.power_mod;
            typed.modulus_error = row.modulus_error;
            put_base(row.base, row.known, typed);
        end

        typed = '0;
        for (p = 0; p < RANDOM_PHASES; p++) begin
            drain_results();
            case ($urandom_range(0, 19))
                0:       m = '0;
                1:       m = DATA_WIDTH'(1);
                2:       m = '1;
                3:       m = DATA_WIDTH'(2);
                4:       m = DATA_WIDTH'(16'h8000);
                5, 6:    m = DATA_WIDTH'($urandom_range(2, 255));
                default: m = DATA_WIDTH'($urandom);
            endcase
            // wide exponents are slow, so most phases keep them short
            case ($urandom_range(0, 9))
                0:       e = '0;
                1:       e = '1;
                2:       e = EXP_WIDTH'($urandom);
                3, 4:    e = EXP_WIDTH'($urandom_range(0, 16'h0FFF));
                default: e = EXP_WIDTH'($urandom_range(0, 255));
            endcase
            set_config(m, e);
            idling_on = (p < QUIET_PHASE) && ($urandom_range(0, 4) != 0);
            if (p == PRESSURE_PHASE)
                hold_off_now = 1'b1;
            for (k = 0; k < PHASE_WORDS; k++) begin
                case ($urandom_range(0, 9))
                    0:       b = '0;
                    1:       b = '1;
                    2:       b = cur_modulus - 1'b1;
                    3:       b = cur_modulus;
                    default: b = DATA_WIDTH'($urandom);
                endcase
                put_base(b, 1'b0, typed);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
